### hw/rtl/cobs_pkg.sv
// Shared types and constants for the COBS frame encoder.
// No dependencies; imported by the encoder top level and by the port checker.
package cobs_pkg;

    localparam int LANES       = 8;
    localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int STORE_DEPTH = 254;
    localparam int MAX_RESULTS = 32;
    localparam int RES_W       = $clog2(MAX_RESULTS);

    localparam logic [7:0] CODE_INIT = 8'h01;
    localparam logic [7:0] CODE_FULL = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } cobs_in_t;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        run_last;
        logic        frame_last;
    } cobs_out_t;

    typedef enum logic [1:0] {
        SRC_CODE,
        SRC_STORE,
        SRC_ONE
    } src_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic              vld;
        src_t              src;
        logic [LANE_W-1:0] lane;
        logic              complete;
        logic              run_last;
        logic              frame_last;
        logic [7:0]        imm;
    } stage_t;

endpackage

### hw/rtl/cobs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cobs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 254
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/cobs_frame_encoder.sv
// COBS frame encoder top level: group store, release sequencer, result packer.
// Depends on cobs_pkg and cobs_ram.
//
//  channel | ports                      | moves
//  --------+----------------------------+------------------------------------
//  input   | s_valid s_ready s_payload  | one raw byte + frame end flag
//  result  | m_valid m_ready m_payload  | up to LANES encoded bytes, run/frame
//
// A release is read out one byte per cycle from the group store read port,
// pausing while each packed result is handed to the output register. Reset
// sets the code to 0x01; the group store is not cleared. A stalled result
// holds the packer and the store reads; new bytes are taken once the last
// read of a release is issued.
module cobs_frame_encoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cobs_pkg::cobs_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output cobs_pkg::cobs_out_t m_payload
);
    import cobs_pkg::*;

    state_t            state_reg, state_next;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        grp_reg, grp_next;
    logic [7:0]        last_reg, last_next;
    logic              fin_reg, fin_next;
    logic [7:0]        idx_reg, idx_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic [RES_W-1:0]  res_reg, res_next;
    stage_t            stg_reg, stg_next;
    logic [63:0]       acc_reg, acc_next;
    logic              acc_done_reg, acc_done_next;
    logic [3:0]        acc_cnt_reg, acc_cnt_next;
    logic              acc_rl_reg, acc_rl_next;
    logic              acc_fl_reg, acc_fl_next;
    logic              m_valid_reg, m_valid_next;
    cobs_out_t         m_payload_reg, m_payload_next;

    logic       accept, b_zero, full, release_any, extra;
    logic [7:0] code_inc, grp_sel;
    logic [8:0] last_wide;
    logic       can_issue, at_last, complete, run_last;
    src_t       src;
    logic       ram_we;
    logic [7:0] ram_waddr, ram_raddr, ram_rdata, stg_byte;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign b_zero      = (s_payload.data_byte == 8'h00);
    assign code_inc    = code_reg + 8'd1;
    assign full        = !b_zero && (code_inc == CODE_FULL);
    assign release_any = b_zero || full || s_payload.frame_end;
    assign extra       = s_payload.frame_end && (b_zero || full);
    assign grp_sel     = b_zero ? code_reg : (full ? CODE_FULL : code_inc);
    assign last_wide   = {1'b0, grp_sel} + {8'd0, extra} - 9'd1;

    assign ram_we    = accept && !b_zero;
    assign ram_waddr = code_reg - 8'd1;
    assign ram_raddr = (idx_reg == 8'd0) ? 8'd0 : idx_reg - 8'd1;

    assign can_issue = (state_reg == ST_EMIT) && !acc_done_reg
                       && !(stg_reg.vld && stg_reg.complete);
    assign at_last   = (idx_reg == last_reg);
    assign complete  = (lane_reg == LANE_W'(LANES - 1)) || at_last;
    assign run_last  = at_last || (complete && res_reg == RES_W'(MAX_RESULTS - 1));

    always_comb begin
        if (idx_reg == 8'd0) begin
            src = SRC_CODE;
        end else if (idx_reg < grp_reg) begin
            src = SRC_STORE;
        end else begin
            src = SRC_ONE;
        end
    end

    always_comb begin
        case (stg_reg.src)
            SRC_STORE: stg_byte = ram_rdata;
            SRC_CODE:  stg_byte = stg_reg.imm;
            SRC_ONE:   stg_byte = stg_reg.imm;
            default:   stg_byte = stg_reg.imm;
        endcase
    end

    cobs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_payload.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        grp_next   = grp_reg;
        last_next  = last_reg;
        fin_next   = fin_reg;
        idx_next   = idx_reg;
        lane_next  = lane_reg;
        res_next   = res_reg;
        stg_next   = stg_reg;
        stg_next.vld = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    code_next = release_any ? CODE_INIT : code_inc;
                    grp_next  = grp_sel;
                    last_next = last_wide[7:0];
                    fin_next  = s_payload.frame_end;
                    idx_next  = 8'd0;
                    lane_next = '0;
                    res_next  = '0;
                    if (release_any) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (can_issue) begin
                    stg_next.vld        = 1'b1;
                    stg_next.src        = src;
                    stg_next.lane       = lane_reg;
                    stg_next.complete   = complete || run_last;
                    stg_next.run_last   = run_last;
                    stg_next.frame_last = run_last && fin_reg;
                    stg_next.imm        = (idx_reg == 8'd0) ? grp_reg : CODE_INIT;
                    idx_next  = idx_reg + 8'd1;
                    lane_next = complete ? '0 : lane_reg + LANE_W'(1);
                    res_next  = complete ? res_reg + RES_W'(1) : res_reg;
                    if (run_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // packer and output register
    always_comb begin
        acc_next       = acc_reg;
        acc_done_next  = acc_done_reg;
        acc_cnt_next   = acc_cnt_reg;
        acc_rl_next    = acc_rl_reg;
        acc_fl_next    = acc_fl_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (acc_done_reg && (!m_valid_reg || m_ready)) begin
            m_valid_next              = 1'b1;
            m_payload_next.out_bytes  = acc_reg;
            m_payload_next.byte_count = acc_cnt_reg;
            m_payload_next.run_last   = acc_rl_reg;
            m_payload_next.frame_last = acc_fl_reg;
            acc_next      = '0;
            acc_done_next = 1'b0;
        end else if (stg_reg.vld) begin
            for (int i = 0; i < LANES; i++) begin
                if (stg_reg.lane == LANE_W'(i)) begin
                    acc_next[8*i +: 8] = stg_byte;
                end
            end
            if (stg_reg.complete) begin
                acc_done_next = 1'b1;
                acc_cnt_next  = 4'(stg_reg.lane) + 4'd1;
                acc_rl_next   = stg_reg.run_last;
                acc_fl_next   = stg_reg.frame_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            code_reg     <= CODE_INIT;
            stg_reg.vld  <= 1'b0;
            acc_reg      <= '0;
            acc_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            code_reg     <= code_next;
            stg_reg      <= stg_next;
            acc_reg      <= acc_next;
            acc_done_reg <= acc_done_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg             <= grp_next;
        last_reg            <= last_next;
        fin_reg             <= fin_next;
        idx_reg             <= idx_next;
        lane_reg            <= lane_next;
        res_reg             <= res_next;
        acc_cnt_reg         <= acc_cnt_next;
        acc_rl_reg          <= acc_rl_next;
        acc_fl_reg          <= acc_fl_next;
        m_payload_reg       <= m_payload_next;
    end

endmodule

### hw/rtl/cobs_chk.sv
// Port-level checks for the COBS frame encoder, bound to the top level.
// Depends on cobs_pkg and cobs_frame_encoder.
module cobs_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input cobs_pkg::cobs_in_t  s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input cobs_pkg::cobs_out_t m_payload
);
    import cobs_pkg::*;

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.byte_count >= 4'd1
                    && m_payload.byte_count <= 4'(LANES))
        else $error("byte_count out of range");

    // only the last result of a run may be short
    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.run_last |-> m_payload.byte_count == 4'(LANES))
        else $error("short result before end of run");

    a_frame_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.frame_last |-> m_payload.run_last)
        else $error("frame_last without run_last");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind cobs_frame_encoder cobs_chk u_cobs_chk (.*);
